[hw/rtl/ctm_pkg.sv]
// Shared types, constants and round functions for the capability tag MAC.
// No dependencies; every other file in hw/rtl imports this package.
package ctm_pkg;

  // SipHash initialization constants
  localparam logic [63:0] SIP_IV0 = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_IV1 = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_IV2 = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_IV3 = 64'h7465646279746573;

  localparam logic [7:0]  MSG_LEN_BYTE = 8'd12;
  localparam logic [63:0] FINAL_XOR    = 64'h00000000000000ff;

  localparam int NUM_DOMAINS = 4;
  localparam int DOM_W       = 2;

  // Pipeline layout: stage 0 loads the initial state, stages 1..4 run the two
  // compression rounds, stages 5..8 the final-block rounds, 9..16 the finalization, per domain.
  localparam int COMP_HALVES = 4;
  localparam int FIN_HALVES  = 12;
  localparam int FIN_START   = COMP_HALVES + 1;
  localparam int FIN_XOR_STG = FIN_START + 4;
  localparam int NUM_STAGES  = 1 + COMP_HALVES + FIN_HALVES;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 2'd1;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } sip_state_t;

  typedef struct packed {
    logic [31:0] resource_id;
    logic [31:0] rights_mask;
    logic [31:0] owner_id;
    logic [63:0] presented_tag_0;
    logic [63:0] presented_tag_1;
    logic [63:0] presented_tag_2;
    logic [63:0] presented_tag_3;
  } cap_in_t;

  typedef struct packed {
    logic [63:0] tag_word_0;
    logic [63:0] tag_word_1;
    logic [63:0] tag_word_2;
    logic [63:0] tag_word_3;
    logic        tag_matches;
  } tag_out_t;

  typedef struct packed {
    sip_state_t [NUM_DOMAINS-1:0]  lane;
    logic [63:0]                   m;
    logic [31:0]                   tail;
    logic [NUM_DOMAINS-1:0][63:0]  presented;
  } stage_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

  // First half of a SipRound: two parallel adds
  function automatic sip_state_t sip_half_a(input sip_state_t s);
    sip_state_t o;
    logic [63:0] a0;
    logic [63:0] a2;
    a0   = s.v0 + s.v1;
    a2   = s.v2 + s.v3;
    o.v1 = rotl(s.v1, 13) ^ a0;
    o.v0 = rotl(a0, 32);
    o.v3 = rotl(s.v3, 16) ^ a2;
    o.v2 = a2;
    return o;
  endfunction

  // Second half of a SipRound
  function automatic sip_state_t sip_half_b(input sip_state_t s);
    sip_state_t o;
    logic [63:0] a0;
    logic [63:0] a2;
    a0   = s.v0 + s.v3;
    a2   = s.v2 + s.v1;
    o.v3 = rotl(s.v3, 21) ^ a0;
    o.v0 = a0;
    o.v1 = rotl(s.v1, 17) ^ a2;
    o.v2 = rotl(a2, 32);
    return o;
  endfunction

  // Final message block: length, domain byte, zero pad, last four bytes
  function automatic logic [63:0] final_block(input logic [31:0] tail,
                                              input logic [DOM_W-1:0] dom);
    return {MSG_LEN_BYTE, {(8-DOM_W){1'b0}}, dom, 16'h0000, tail};
  endfunction

endpackage

[hw/rtl/ctm_sip_pipe.sv]
// Half-round SipHash-2-4 pipeline with per-stage valid and bubble collapse.
// Depends on ctm_pkg for the stage record and round functions.
module ctm_sip_pipe (
  input  logic              clk,
  input  logic              rst,
  input  logic [63:0]       key_low,
  input  logic [63:0]       key_high,
  input  logic              cap_valid,
  output logic              cap_ready,
  input  ctm_pkg::cap_in_t  cap_data,
  output logic              res_valid,
  input  logic              res_ready,
  output ctm_pkg::tag_out_t res_data
);
  import ctm_pkg::*;

  stage_t                  stage      [NUM_STAGES];
  stage_t                  stage_next [NUM_STAGES];
  logic [NUM_STAGES-1:0]   valid;
  logic [NUM_STAGES:0]     en;
  tag_out_t                res_next;

  // Load enables: a stage moves when it is empty or its successor moves
  assign en[NUM_STAGES] = !res_valid || res_ready;
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_en
    assign en[k] = !valid[k] || en[k+1];
  end
  assign cap_ready = en[0];

  // Stage 0: keyed initial state with the first message word in v3
  always_comb begin
    logic [63:0] m;
    m = {cap_data.rights_mask, cap_data.resource_id};
    stage_next[0]            = '0;
    stage_next[0].lane[0].v0 = SIP_IV0 ^ key_low;
    stage_next[0].lane[0].v1 = SIP_IV1 ^ key_high;
    stage_next[0].lane[0].v2 = SIP_IV2 ^ key_low;
    stage_next[0].lane[0].v3 = SIP_IV3 ^ key_high ^ m;
    stage_next[0].m          = m;
    stage_next[0].tail       = cap_data.owner_id;
    stage_next[0].presented  = {cap_data.presented_tag_3, cap_data.presented_tag_2,
                                cap_data.presented_tag_1, cap_data.presented_tag_0};
  end

  // Stages 1..16: one half-round each
  for (genvar k = 1; k < NUM_STAGES; k++) begin : g_stage
    stage_t pre;

    always_comb begin
      pre = stage[k-1];
      // fan the compressed state out to the four domains
      if (k == FIN_START) begin
        for (int d = 0; d < NUM_DOMAINS; d++) begin
          pre.lane[d]    = stage[k-1].lane[0];
          pre.lane[d].v0 = stage[k-1].lane[0].v0 ^ stage[k-1].m;
          pre.lane[d].v3 = stage[k-1].lane[0].v3
                           ^ final_block(stage[k-1].tail, DOM_W'(d));
        end
      end
      // end of the final-block rounds
      if (k == FIN_XOR_STG) begin
        for (int d = 0; d < NUM_DOMAINS; d++) begin
          pre.lane[d].v0 = stage[k-1].lane[d].v0
                           ^ final_block(stage[k-1].tail, DOM_W'(d));
          pre.lane[d].v2 = stage[k-1].lane[d].v2 ^ FINAL_XOR;
        end
      end
    end

    always_comb begin
      stage_next[k] = pre;
      for (int d = 0; d < NUM_DOMAINS; d++) begin
        if (d != 0 && k < FIN_START) begin
          stage_next[k].lane[d] = '0;
        end else if (k % 2 == 1) begin
          stage_next[k].lane[d] = sip_half_a(pre.lane[d]);
        end else begin
          stage_next[k].lane[d] = sip_half_b(pre.lane[d]);
        end
      end
    end
  end

  // Output stage: fold the state and compare with the presented tag
  always_comb begin
    logic [NUM_DOMAINS-1:0][63:0] w;
    logic [NUM_DOMAINS-1:0]       eq;
    for (int d = 0; d < NUM_DOMAINS; d++) begin
      w[d]  = stage[NUM_STAGES-1].lane[d].v0 ^ stage[NUM_STAGES-1].lane[d].v1
            ^ stage[NUM_STAGES-1].lane[d].v2 ^ stage[NUM_STAGES-1].lane[d].v3;
      eq[d] = (w[d] == stage[NUM_STAGES-1].presented[d]);
    end
    res_next.tag_word_0  = w[0];
    res_next.tag_word_1  = w[1];
    res_next.tag_word_2  = w[2];
    res_next.tag_word_3  = w[3];
    res_next.tag_matches = &eq;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (en[0]) begin
        valid[0] <= cap_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
      if (en[NUM_STAGES]) begin
        res_valid <= valid[NUM_STAGES-1];
      end
    end
  end

  // Stage data, no reset
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        stage[k] <= stage_next[k];
      end
    end
    if (en[NUM_STAGES]) begin
      res_data <= res_next;
    end
  end

endmodule

[hw/rtl/capability_tag_mac_core.sv]
// Top level of the capability tag MAC: key registers and the hash pipeline.
// Depends on ctm_pkg and ctm_sip_pipe.
//
//   channel   signals                                   direction
//   cap       cap_valid / cap_ready / cap_data          in
//   res       res_valid / res_ready / res_data          out
//   cfg       cfg_valid / cfg_ready / cfg_index, _data  in
//
// One capability is taken per cycle while cap_ready is high; its result passes
// through 17 pipeline stages (key setup plus 16 SipHash half-rounds), the
// first loaded at the transfer edge, then the output register holding the
// folded words and the match flag.
// Reset clears the keys to zero and empties the pipeline.
// A stalled result holds the output; stages behind it keep filling bubbles,
// so input is refused only when every stage holds an item.
module capability_tag_mac_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cap_valid,
  output logic                             cap_ready,
  input  ctm_pkg::cap_in_t                 cap_data,
  output logic                             res_valid,
  input  logic                             res_ready,
  output ctm_pkg::tag_out_t                res_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ctm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [63:0]                      cfg_data
);
  import ctm_pkg::*;

  logic [63:0] key_low;
  logic [63:0] key_high;

  assign cfg_ready = 1'b1;

  // Key registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_KEY_LOW:  key_low  <= cfg_data;
        REG_KEY_HIGH: key_high <= cfg_data;
        default: ;
      endcase
    end
  end

  ctm_sip_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .key_low   (key_low),
    .key_high  (key_high),
    .cap_valid (cap_valid),
    .cap_ready (cap_ready),
    .cap_data  (cap_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule

[hw/rtl/ctm_checker.sv]
// Port-level checks for capability_tag_mac_core, attached with bind.
// Depends on ctm_pkg for the result type.
module ctm_checker (
  input logic              clk,
  input logic              rst,
  input logic              cap_ready,
  input logic              res_valid,
  input logic              res_ready,
  input ctm_pkg::tag_out_t res_data
);
  import ctm_pkg::*;

  // Pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // A stalled result keeps its transfer data
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("stalled result changed");

  // Input is refused only when the output is backed up
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !cap_ready |-> res_valid && !res_ready)
    else $error("input refused without output stall");

  // After reset the block takes input at once
  a_ready_after_reset: assert property (@(posedge clk) $fell(rst) |-> cap_ready)
    else $error("not ready after reset");

endmodule

bind capability_tag_mac_core ctm_checker u_ctm_checker (.*);
